>>> rtl/core/uart_rb_pkg.sv
package uart_rb_pkg;

    // event codes of an input item
    typedef enum logic [2:0] {
        ACT_SEND  = 3'd0,
        ACT_RECV  = 3'd1,
        ACT_READ  = 3'd2,
        ACT_DONE  = 3'd3,
        ACT_ERROR = 3'd4
    } t_action;

    // what a result item gives out
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_TX   = 2'd1,
        KIND_READ = 2'd2,
        KIND_FWD  = 2'd3
    } t_kind;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // queue control from the sequencer
    typedef struct packed {
        logic rd_en;
        logic push;
        logic pop;
    } t_q_ctl;

    // queue status back to the sequencer
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

>>> rtl/core/uart_rb_in_if.sv
interface uart_rb_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] data_byte;
    logic [15:0] error_code;

    modport source (output valid, output action, output data_byte, output error_code,
                    input ready);
    modport sink (input valid, input action, input data_byte, input error_code,
                  output ready);
endinterface

>>> rtl/core/uart_rb_out_if.sv
interface uart_rb_out_if #(
    parameter int TX_LW = 13,
    parameter int RX_LW = 11
);
    logic             valid;
    logic             ready;
    logic [1:0]       out_kind;
    logic [7:0]       out_byte;
    logic             tx_busy;
    logic [TX_LW-1:0] tx_level;
    logic [RX_LW-1:0] rx_level;
    logic [15:0]      tx_overflows;
    logic [15:0]      rx_overflows;
    logic [31:0]      tx_sent;
    logic [31:0]      rx_forwarded;
    logic [15:0]      error_total;
    logic [15:0]      last_error;

    modport source (output valid, output out_kind, output out_byte, output tx_busy,
                    output tx_level, output rx_level, output tx_overflows,
                    output rx_overflows, output tx_sent, output rx_forwarded,
                    output error_total, output last_error, input ready);
    modport sink (input valid, input out_kind, input out_byte, input tx_busy,
                  input tx_level, input rx_level, input tx_overflows,
                  input rx_overflows, input tx_sent, input rx_forwarded,
                  input error_total, input last_error, output ready);
endinterface

>>> rtl/core/uart_tx_rx_ring_buffer_top.sv
// channel    | dir | handshake     | payload
// i_item     | in  | valid / ready | action, data_byte, error_code
// o_result   | out | valid / ready | out_kind, out_byte, tx_busy, levels, counters
// i_cfg_*    | in  | write enable  | rx_bypass
//
// each item is taken in S_IDLE, where the accept reads the head of both queue
// memories; S_EXEC then updates state, writes the memory and loads the result
// S_EXEC waits while the output register still holds an untaken result;
// a new item is accepted while a result waits to be taken
// synchronous active-low reset clears pointers, fills, counters and busy;
// queue memories are not cleared, a pop only ever reads entries a push wrote
module uart_tx_rx_ring_buffer_top #(
    parameter int TX_DEPTH = 4096,
    parameter int RX_DEPTH = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    uart_rb_in_if.sink    i_item,
    uart_rb_out_if.source o_result
);
    import uart_rb_pkg::*;

    localparam int TX_CW = $clog2(TX_DEPTH + 1);
    localparam int RX_CW = $clog2(RX_DEPTH + 1);

    t_state      r_state, n_state;
    logic [2:0]  r_action;
    logic [7:0]  r_data;
    logic [15:0] r_code;
    logic        r_bypass;

    // line and statistics state
    logic        r_busy, n_busy;
    logic [15:0] r_tx_drop;
    logic [15:0] r_rx_drop;
    logic [31:0] r_sent;
    logic [31:0] r_fwd;
    logic [15:0] r_err_tally;
    logic [15:0] r_err_code;

    // result register
    logic        r_out_valid;
    t_kind       r_out_kind, n_out_kind;
    logic [7:0]  r_out_byte, n_out_byte;

    logic        accept;
    logic        exec;
    logic        in_ready;
    logic        inc_tx_drop, inc_rx_drop, inc_sent, inc_fwd, take_err;

    t_q_ctl      tx_ctl, rx_ctl;
    t_q_stat     tx_stat, rx_stat;
    logic [7:0]  tx_head, rx_head;
    logic [TX_CW-1:0] tx_count;
    logic [RX_CW-1:0] rx_count;

    assign accept = i_item.valid && in_ready;

    // sequencer: next state and handshake
    always_comb begin
        n_state  = r_state;
        in_ready = 1'b0;
        exec     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_item.valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // result slot must be free or freed this cycle
                if (!r_out_valid || o_result.ready) begin
                    exec    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // event decode against the queue heads read in the accept cycle
    always_comb begin
        tx_ctl       = '0;
        rx_ctl       = '0;
        tx_ctl.rd_en = accept;
        rx_ctl.rd_en = accept;
        n_busy       = r_busy;
        n_out_kind   = KIND_NONE;
        n_out_byte   = '0;
        inc_tx_drop  = 1'b0;
        inc_rx_drop  = 1'b0;
        inc_sent     = 1'b0;
        inc_fwd      = 1'b0;
        take_err     = 1'b0;
        if (exec) begin
            unique case (r_action)
                ACT_SEND: begin
                    tx_ctl.push = !tx_stat.full;
                    inc_tx_drop = tx_stat.full;
                    if (!r_busy) begin
                        // idle line: issue the head at once, which is the new
                        // byte itself when the queue was empty
                        n_busy     = 1'b1;
                        tx_ctl.pop = 1'b1;
                        n_out_kind = KIND_TX;
                        n_out_byte = tx_stat.empty ? r_data : tx_head;
                    end
                end
                ACT_RECV: begin
                    if (r_bypass) begin
                        inc_fwd    = 1'b1;
                        n_out_kind = KIND_FWD;
                        n_out_byte = r_data;
                    end else begin
                        rx_ctl.push = !rx_stat.full;
                        inc_rx_drop = rx_stat.full;
                    end
                end
                ACT_READ: begin
                    if (!rx_stat.empty) begin
                        rx_ctl.pop = 1'b1;
                        n_out_kind = KIND_READ;
                        n_out_byte = rx_head;
                    end
                end
                ACT_DONE: begin
                    if (!tx_stat.empty) begin
                        tx_ctl.pop = 1'b1;
                        n_busy     = 1'b1;
                        inc_sent   = 1'b1;
                        n_out_kind = KIND_TX;
                        n_out_byte = tx_head;
                    end else begin
                        n_busy = 1'b0;
                    end
                end
                ACT_ERROR: begin
                    take_err = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // item payload capture and config register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_item.action;
            r_data   <= i_item.data_byte;
            r_code   <= i_item.error_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bypass <= 1'b0;
        end else if (i_cfg_we) begin
            r_bypass <= i_cfg_wdata;
        end
    end

    // line state and wrapping counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_tx_drop   <= '0;
            r_rx_drop   <= '0;
            r_sent      <= '0;
            r_fwd       <= '0;
            r_err_tally <= '0;
            r_err_code  <= '0;
        end else begin
            r_busy <= n_busy;
            if (inc_tx_drop) begin
                r_tx_drop <= r_tx_drop + 1'b1;
            end
            if (inc_rx_drop) begin
                r_rx_drop <= r_rx_drop + 1'b1;
            end
            if (inc_sent) begin
                r_sent <= r_sent + 1'b1;
            end
            if (inc_fwd) begin
                r_fwd <= r_fwd + 1'b1;
            end
            if (take_err) begin
                r_err_tally <= r_err_tally + 1'b1;
                r_err_code  <= r_code;
            end
        end
    end

    // result register; status fields come live from state, which only moves
    // when the result slot is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out_kind <= n_out_kind;
            r_out_byte <= n_out_byte;
        end
    end

    uart_rb_queue #(
        .DEPTH (TX_DEPTH)
    ) u_tx_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (tx_ctl),
        .i_wdata (r_data),
        .o_head  (tx_head),
        .o_count (tx_count),
        .o_stat  (tx_stat)
    );

    uart_rb_queue #(
        .DEPTH (RX_DEPTH)
    ) u_rx_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rx_ctl),
        .i_wdata (r_data),
        .o_head  (rx_head),
        .o_count (rx_count),
        .o_stat  (rx_stat)
    );

    assign i_item.ready          = in_ready;
    assign o_result.valid        = r_out_valid;
    assign o_result.out_kind     = r_out_kind;
    assign o_result.out_byte     = r_out_byte;
    assign o_result.tx_busy      = r_busy;
    assign o_result.tx_level     = tx_count;
    assign o_result.rx_level     = rx_count;
    assign o_result.tx_overflows = r_tx_drop;
    assign o_result.rx_overflows = r_rx_drop;
    assign o_result.tx_sent      = r_sent;
    assign o_result.rx_forwarded = r_fwd;
    assign o_result.error_total  = r_err_tally;
    assign o_result.last_error   = r_err_code;
endmodule

>>> rtl/core/uart_rb_ram.sv
module uart_rb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/uart_rb_queue.sv
module uart_rb_queue #(
    parameter int DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  uart_rb_pkg::t_q_ctl        i_ctl,
    input  logic [7:0]                 i_wdata,
    output logic [7:0]                 o_head,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output uart_rb_pkg::t_q_stat       o_stat
);
    import uart_rb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [CW-1:0] r_count, n_count;

    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_count  = r_count;
        if (i_ctl.push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_ctl.pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        // push and pop together leave the fill unchanged
        if (i_ctl.push && !i_ctl.pop) begin
            n_count = r_count + 1'b1;
        end else if (i_ctl.pop && !i_ctl.push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
    end

    uart_rb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.push),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_wdata),
        .i_re    (i_ctl.rd_en),
        .i_raddr (r_rd_ptr),
        .o_rdata (o_head)
    );

    assign o_count      = r_count;
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(DEPTH));
endmodule
